@@ sv/escaped_frame_deframer_top_macros.svh @@
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Concurrent assertion wrappers clocked on clk and held off during rst_n.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_DEFRAMER_TOP_MACROS_SVH
`define ESCAPED_FRAME_DEFRAMER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// check cons in the same cycle as ante
`define EFD_ASSERT_HOLDS(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("escaped_frame_deframer: same-cycle check failed");
// check cons in the cycle after ante
`define EFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("escaped_frame_deframer: next-cycle check failed");
`else
`define EFD_ASSERT_HOLDS(label, ante, cons)
`define EFD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ sv/efd_pkg.sv @@
// ----------------------------------------------------------------------------
// Deframer package
// Types, codes and reset constants shared by the deframer modules.
// ----------------------------------------------------------------------------
package efd_pkg;

    localparam logic [7:0] START_BYTE_RESET  = 8'hE0;
    localparam logic [7:0] ESCAPE_BYTE_RESET = 8'hD0;

    // configuration register indexes
    localparam logic CFG_START_BYTE  = 1'b0;
    localparam logic CFG_ESCAPE_BYTE = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2,
        PH_SUM  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        KIND_BODY       = 3'd0,
        KIND_GOOD       = 3'd1,
        KIND_BAD        = 3'd2,
        KIND_INCOMPLETE = 3'd3,
        KIND_BAD_LENGTH = 3'd4
    } kind_t;

    typedef struct packed {
        phase_t     phase;
        logic       escape_pending;
        logic [7:0] running_sum;
        logic [7:0] body_position;
        logic [7:0] length_seen;
    } efd_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [7:0] frame_length;
    } efd_result_t;

    localparam efd_state_t STATE_IDLE = '{
        phase:          PH_HUNT,
        escape_pending: 1'b0,
        running_sum:    8'd0,
        body_position:  8'd1,
        length_seen:    8'd0
    };

endpackage

@@ sv/efd_step.sv @@
// ----------------------------------------------------------------------------
// Deframer step logic
// Next frame state and the optional result for one received byte.
// ----------------------------------------------------------------------------
module efd_step (
    input  efd_pkg::efd_state_t  state,
    input  logic [7:0]           rx_byte,
    input  logic                 last_in_buffer,
    input  logic [7:0]           start_byte,
    input  logic [7:0]           escape_byte,
    output efd_pkg::efd_state_t  state_next,
    output logic                 emit,
    output efd_pkg::efd_result_t result
);
    import efd_pkg::*;

    logic       is_start;
    logic       is_escape;
    logic [7:0] value;
    logic [7:0] position_inc;

    assign is_start     = (rx_byte == start_byte);
    assign is_escape    = (rx_byte == escape_byte);
    assign value        = state.escape_pending ? rx_byte + 8'd1 : rx_byte;
    assign position_inc = state.body_position + 8'd1;

    // next state
    always_comb
    begin
        state_next = state;
        case (state.phase)
            PH_HUNT:
            begin
                if (is_start)
                begin
                    state_next.phase = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (rx_byte == 8'd0)
                begin
                    state_next = STATE_IDLE;
                end
                else
                begin
                    state_next.length_seen    = rx_byte;
                    state_next.running_sum    = rx_byte;
                    state_next.body_position  = 8'd1;
                    state_next.escape_pending = 1'b0;
                    state_next.phase          = (rx_byte == 8'd1) ? PH_SUM : PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (is_escape)
                begin
                    state_next.escape_pending = 1'b1;
                end
                else
                begin
                    state_next.escape_pending = 1'b0;
                    state_next.running_sum    = state.running_sum + value;
                    state_next.body_position  = position_inc;
                    if (position_inc == state.length_seen)
                    begin
                        state_next.phase = PH_SUM;
                    end
                end
            end
            PH_SUM:
            begin
                if (!state.escape_pending && is_escape)
                begin
                    state_next.escape_pending = 1'b1;
                end
                else
                begin
                    state_next = STATE_IDLE;
                end
            end
            default:
            begin
                state_next = STATE_IDLE;
            end
        endcase
        // buffer end drops whatever frame is open
        if (last_in_buffer)
        begin
            state_next = STATE_IDLE;
        end
    end

    // result
    always_comb
    begin
        emit                = 1'b0;
        result.kind         = KIND_BODY;
        result.data_byte    = 8'd0;
        result.byte_index   = 8'd0;
        result.frame_length = state.length_seen;
        case (state.phase)
            PH_HUNT:
            begin
                if (is_start && last_in_buffer)
                begin
                    emit                = 1'b1;
                    result.kind         = KIND_INCOMPLETE;
                    result.frame_length = 8'd0;
                end
            end
            PH_LEN:
            begin
                if (rx_byte == 8'd0)
                begin
                    emit                = 1'b1;
                    result.kind         = KIND_BAD_LENGTH;
                    result.frame_length = 8'd0;
                end
                else
                begin
                    result.frame_length = rx_byte;
                    if (last_in_buffer)
                    begin
                        emit        = 1'b1;
                        result.kind = KIND_INCOMPLETE;
                    end
                end
            end
            PH_BODY:
            begin
                if (last_in_buffer)
                begin
                    emit        = 1'b1;
                    result.kind = KIND_INCOMPLETE;
                end
                else if (!is_escape)
                begin
                    emit              = 1'b1;
                    result.kind       = KIND_BODY;
                    result.data_byte  = value;
                    result.byte_index = state.body_position;
                end
            end
            PH_SUM:
            begin
                if (!state.escape_pending && is_escape)
                begin
                    if (last_in_buffer)
                    begin
                        emit        = 1'b1;
                        result.kind = KIND_INCOMPLETE;
                    end
                end
                else
                begin
                    emit             = 1'b1;
                    result.kind      = (state.running_sum == value) ? KIND_GOOD : KIND_BAD;
                    result.data_byte = value;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

endmodule

@@ sv/escaped_frame_deframer_top.sv @@
// ----------------------------------------------------------------------------
// Escaped frame deframer
// Byte-stuffed frame parser with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
// Input channel: one received byte per item (rx_byte, last_in_buffer) on
// in_valid / in_stall. Output channel: zero or one result per item (kind,
// data_byte, byte_index, frame_length) on out_valid / out_stall. Body bytes
// come out unescaped with their position; the checksum byte gives good or
// bad; a buffer end before the checksum gives incomplete; a zero length
// byte gives bad length.
// Path: an item waits in the input register until the result register is free
// or being taken; its result is then registered in the result register and
// held on the output until taken.
// Throughput: one item per cycle while the output is not stalled, set by the
// frame state update between the input register and the result register.
// A stalled output holds its result and the item behind it in the input
// register; in_stall rises once both registers are full.
// Reset clears both registers, returns the parser to hunting and loads the
// default start byte (0xE0) and escape byte (0xD0). Write cfg_* only while
// no item is in flight.
// ----------------------------------------------------------------------------
`include "escaped_frame_deframer_top_macros.svh"

module escaped_frame_deframer_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       last_in_buffer,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] kind,
    output logic [7:0] data_byte,
    output logic [7:0] byte_index,
    output logic [7:0] frame_length
);
    import efd_pkg::*;

    logic        start_write;
    logic [7:0]  start_reg;
    logic [7:0]  escape_reg;

    logic        item_valid_reg;
    logic        item_valid_next;
    logic [7:0]  rx_byte_reg;
    logic        last_reg;

    efd_state_t  state_reg;
    efd_state_t  state_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    efd_result_t result_reg;

    logic        emit;
    efd_result_t result;
    logic        advance;
    logic        accept;

    assign start_write = cfg_write && (cfg_index == CFG_START_BYTE);

    // move the held item on when the result slot is free or being taken
    assign advance  = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    efd_step u_step (
        .state          (state_reg),
        .rx_byte        (rx_byte_reg),
        .last_in_buffer (last_reg),
        .start_byte     (start_reg),
        .escape_byte    (escape_reg),
        .state_next     (state_next),
        .emit           (emit),
        .result         (result)
    );

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = emit;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg      <= START_BYTE_RESET;
            escape_reg     <= ESCAPE_BYTE_RESET;
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= STATE_IDLE;
        end
        else
        begin
            if (start_write)
            begin
                start_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == CFG_ESCAPE_BYTE))
            begin
                escape_reg <= cfg_data;
            end
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rx_byte_reg <= rx_byte;
            last_reg    <= last_in_buffer;
        end
        if (advance && emit)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = result_reg.kind;
    assign data_byte    = result_reg.data_byte;
    assign byte_index   = result_reg.byte_index;
    assign frame_length = result_reg.frame_length;

    `EFD_ASSERT_HOLDS(a_hunt_clean, state_reg.phase == PH_HUNT,
        !state_reg.escape_pending && state_reg.length_seen == 8'd0 && state_reg.running_sum == 8'd0)
    `EFD_ASSERT_HOLDS(a_body_len, state_reg.phase == PH_BODY,
        state_reg.length_seen >= 8'd2 && state_reg.body_position < state_reg.length_seen)
    `EFD_ASSERT_HOLDS(a_body_index, out_valid_reg && result_reg.kind == KIND_BODY,
        result_reg.byte_index != 8'd0)
    `EFD_ASSERT_HOLDS(a_end_index, out_valid_reg && result_reg.kind != KIND_BODY,
        result_reg.byte_index == 8'd0)
    `EFD_ASSERT_NEXT(a_buffer_end, advance && last_reg,
        state_reg.phase == PH_HUNT && !state_reg.escape_pending)

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Escaped frame deframer testbench
// Sends raw serial bytes into the deframer, predicts every body byte and
// frame end in a local parser model, and checks each result in order.
// Covers directed corner frames, register changes, random framed traffic
// with escapes and truncation, and a long output hold that fills the block.
// ----------------------------------------------------------------------------
module tb_top;

    import efd_pkg::*;

    typedef enum {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write = 1'b0;
    logic       cfg_index = 1'b0;
    logic [7:0] cfg_data = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'd0;
    logic       last_in_buffer = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_length;

    // parser model state and register copies
    logic [7:0] start_cfg = START_BYTE_RESET;
    logic [7:0] esc_cfg = ESCAPE_BYTE_RESET;
    phase_t     frame_phase = PH_HUNT;
    logic       esc_armed = 1'b0;
    logic [7:0] frame_sum = 8'd0;
    logic [7:0] body_pos = 8'd1;
    logic [7:0] held_len = 8'd0;

    efd_result_t due_events[$];

    int       error_count = 0;
    int       bytes_sent = 0;
    int       results_checked = 0;
    int       kind_count[8];
    int       settings_count = 0;
    int       burst_left = 0;
    bit       gaps_on = 1'b0;
    rx_mode_t rx_mode = RX_FREE;
    int       hold_request = 0;
    int       hold_left = 0;
    int       stall_phase = 0;

    escaped_frame_deframer_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .last_in_buffer (last_in_buffer),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .frame_length   (frame_length)
    );

    always #5 clk = ~clk;

    function automatic void drop_frame();
        frame_phase = PH_HUNT;
        esc_armed = 1'b0;
        frame_sum = 8'd0;
        body_pos = 8'd1;
        held_len = 8'd0;
    endfunction

    // Advance the parser by one byte; returns 1 when the byte yields a result.
    function automatic bit parse_byte(input logic [7:0] b, input logic ends_buffer,
                                      output efd_result_t res);
        bit         emit = 1'b0;
        bit         closes = 1'b0;
        logic [7:0] v;
        res.kind = KIND_BODY;
        res.data_byte = 8'd0;
        res.byte_index = 8'd0;
        res.frame_length = held_len;
        case (frame_phase)
            PH_HUNT:
            begin
                if (b == start_cfg)
                begin
                    if (ends_buffer)
                    begin
                        emit = 1'b1;
                        res.kind = KIND_INCOMPLETE;
                        res.frame_length = 8'd0;
                    end
                    else
                        frame_phase = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (b == 8'd0)
                begin
                    emit = 1'b1;
                    closes = 1'b1;
                    res.kind = KIND_BAD_LENGTH;
                    res.frame_length = 8'd0;
                end
                else
                begin
                    held_len = b;
                    res.frame_length = b;
                    frame_sum = b;
                    body_pos = 8'd1;
                    esc_armed = 1'b0;
                    frame_phase = (b == 8'd1) ? PH_SUM : PH_BODY;
                    if (ends_buffer)
                    begin
                        emit = 1'b1;
                        res.kind = KIND_INCOMPLETE;
                    end
                end
            end
            PH_BODY:
            begin
                if (b == esc_cfg)
                    esc_armed = 1'b1;
                else
                begin
                    v = esc_armed ? 8'(b + 8'd1) : b;
                    esc_armed = 1'b0;
                    frame_sum = 8'(frame_sum + v);
                    emit = 1'b1;
                    res.data_byte = v;
                    res.byte_index = body_pos;
                    body_pos = 8'(body_pos + 8'd1);
                    if (body_pos == held_len)
                        frame_phase = PH_SUM;
                end
                // buffer end overrides a body byte
                if (ends_buffer)
                begin
                    emit = 1'b1;
                    res.kind = KIND_INCOMPLETE;
                    res.data_byte = 8'd0;
                    res.byte_index = 8'd0;
                end
            end
            default:
            begin
                if (!esc_armed && b == esc_cfg)
                begin
                    esc_armed = 1'b1;
                    if (ends_buffer)
                    begin
                        emit = 1'b1;
                        res.kind = KIND_INCOMPLETE;
                    end
                end
                else
                begin
                    v = esc_armed ? 8'(b + 8'd1) : b;
                    esc_armed = 1'b0;
                    emit = 1'b1;
                    closes = 1'b1;
                    if (frame_sum == v)
                        res.kind = KIND_GOOD;
                    else
                        res.kind = KIND_BAD;
                    res.data_byte = v;
                end
            end
        endcase
        if (ends_buffer || closes)
            drop_frame();
        return emit;
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH result %0d field %s: got %02h want %02h",
                 results_checked, field, got, want);
        error_count++;
    endtask

    // Check results and predict at the rising edge.
    always @(posedge clk)
    begin : watch_ports
        efd_result_t want;
        efd_result_t next_res;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (due_events.size() == 0)
                    report_mismatch("unexpected", {5'd0, kind}, 8'd0);
                else
                begin
                    want = due_events.pop_front();
                    if (kind !== want.kind)
                        report_mismatch("kind", {5'd0, kind}, {5'd0, want.kind});
                    if (data_byte !== want.data_byte)
                        report_mismatch("data_byte", data_byte, want.data_byte);
                    if (byte_index !== want.byte_index)
                        report_mismatch("byte_index", byte_index, want.byte_index);
                    if (frame_length !== want.frame_length)
                        report_mismatch("frame_length", frame_length, want.frame_length);
                    kind_count[want.kind]++;
                end
                results_checked++;
            end
            if (in_valid && !in_stall)
            begin
                if (parse_byte(rx_byte, last_in_buffer, next_res))
                    due_events.push_back(next_res);
            end
        end
    end

    // Receiver: long hold when asked, otherwise the selected stall pattern.
    always @(negedge clk)
    begin
        stall_phase++;
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else
        begin
            case (rx_mode)
                RX_FREE:   out_stall = 1'b0;
                RX_RANDOM: out_stall = ($urandom_range(0, 3) == 0);
                default:   out_stall = ((stall_phase % 7) < 3);
            endcase
        end
    end

    task automatic send_item(input logic [7:0] b, input logic ends_buffer);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        in_valid = 1'b1;
        rx_byte = b;
        last_in_buffer = ends_buffer;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    // Drop valid, wait out all results, then let in-flight bytes drain.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (due_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx == CFG_START_BYTE)
            start_cfg = val;
        else
            esc_cfg = val;
    endtask

    task automatic set_markers(input logic [7:0] start_val, input logic [7:0] esc_val);
        settle();
        write_reg(CFG_START_BYTE, start_val);
        write_reg(CFG_ESCAPE_BYTE, esc_val);
        settings_count++;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 31))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return start_cfg;
            3:       return esc_cfg;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Encode one body or checksum value, escaping where needed or at random.
    task automatic send_value(input logic [7:0] v, input bit is_sum, input bit ends_buffer);
        bit escaped;
        escaped = (v == esc_cfg) ||
                  ($urandom_range(0, 3) == 0 && (is_sum || 8'(v - 8'd1) != esc_cfg));
        if (!escaped)
            send_item(v, ends_buffer);
        else
        begin
            // doubled escape in the body stays pending
            if (!is_sum && $urandom_range(0, 7) == 0)
                send_item(esc_cfg, 1'b0);
            if (ends_buffer && $urandom_range(0, 1) == 1)
                send_item(esc_cfg, 1'b1);
            else
            begin
                send_item(esc_cfg, 1'b0);
                send_item(8'(v - 8'd1), ends_buffer);
            end
        end
    endtask

    // Line noise, then one frame; a negative length picks one at random.
    task automatic send_random_frame(input int force_len);
        int         len;
        int         cut;
        int         pos;
        logic [7:0] v;
        logic [7:0] sum;
        repeat ($urandom_range(0, 2))
        begin
            do v = 8'($urandom_range(0, 255)); while (v == start_cfg);
            send_item(v, $urandom_range(0, 15) == 0);
        end
        if (force_len >= 0)
            len = force_len;
        else
        begin
            pos = $urandom_range(0, 99);
            if (pos < 4)
                len = 0;
            else if (pos < 10)
                len = 1;
            else if (pos < 98)
                len = $urandom_range(2, 12);
            else
                len = $urandom_range(13, 80);
        end
        // element at which the buffer ends early: start, length or a body byte
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len + 1;
        send_item(start_cfg, cut == 0);
        if (cut == 0)
            return;
        send_item(8'(len), cut == 1);
        if (cut == 1 || len == 0)
            return;
        sum = 8'(len);
        for (pos = 2; pos <= len; pos++)
        begin
            v = pick_byte();
            sum = 8'(sum + v);
            send_value(v, 1'b0, cut == pos);
            if (cut == pos)
                return;
        end
        if ($urandom_range(0, 3) == 0)
            sum = pick_byte();
        send_value(sum, 1'b1, $urandom_range(0, 3) == 0);
    endtask

    task automatic test_directed_defaults();
        gaps_on = 1'b0;
        rx_mode = RX_FREE;
        // good frame: escaped 0xFF wraps to 0x00, escaped checksum
        send_item(START_BYTE_RESET, 1'b0);
        send_item(8'h03, 1'b0);
        send_item(ESCAPE_BYTE_RESET, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h05, 1'b0);
        send_item(ESCAPE_BYTE_RESET, 1'b0);
        send_item(8'h07, 1'b0);
        // length one goes straight to a wrong checksum
        send_item(START_BYTE_RESET, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'h02, 1'b0);
        // zero length, then zero length at the buffer end
        send_item(START_BYTE_RESET, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(START_BYTE_RESET, 1'b0);
        send_item(8'h00, 1'b1);
        // buffer end while hunting, on noise and on the start byte
        send_item(8'h55, 1'b1);
        send_item(START_BYTE_RESET, 1'b1);
        // buffer end on an escape after one body byte
        send_item(START_BYTE_RESET, 1'b0);
        send_item(8'h05, 1'b0);
        send_item(8'h11, 1'b0);
        send_item(ESCAPE_BYTE_RESET, 1'b1);
        // buffer end on the length byte
        send_item(START_BYTE_RESET, 1'b0);
        send_item(8'h04, 1'b1);
        // buffer end on an escape in the checksum
        send_item(START_BYTE_RESET, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(ESCAPE_BYTE_RESET, 1'b1);
    endtask

    task automatic test_register_settings();
        set_markers(8'h04, 8'h02);
        rx_mode = RX_RANDOM;
        // length equal to the escape byte; escape twice in the body
        send_item(8'h04, 1'b0);
        send_item(8'h02, 1'b0);
        send_item(8'h02, 1'b0);
        send_item(8'h02, 1'b0);
        send_item(8'h04, 1'b0);
        send_item(8'h02, 1'b0);
        send_item(8'h06, 1'b0);
        // length equal to the start byte; start byte as data; escaped escape
        // byte as checksum
        send_item(8'h04, 1'b0);
        send_item(8'h04, 1'b0);
        send_item(8'h04, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h02, 1'b0);
        send_item(8'h02, 1'b0);
    endtask

    task automatic test_random_traffic(input logic [7:0] start_val, input logic [7:0] esc_val,
                                       input int n, input bit gaps, input rx_mode_t mode,
                                       input bit with_longest);
        int stop_at;
        set_markers(start_val, esc_val);
        gaps_on = gaps;
        rx_mode = mode;
        stop_at = bytes_sent + n;
        if (with_longest)
            send_random_frame(255);
        while (bytes_sent < stop_at)
            send_random_frame(-1);
    endtask

    // Hold the output for a long stretch while bytes keep coming.
    task automatic test_output_hold();
        int stop_at;
        set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        gaps_on = 1'b0;
        rx_mode = RX_FREE;
        hold_request = 300;
        stop_at = bytes_sent + 150;
        while (bytes_sent < stop_at)
            send_random_frame(-1);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed_defaults();
        test_register_settings();
        test_random_traffic(START_BYTE_RESET, ESCAPE_BYTE_RESET, 230, 1'b1, RX_RANDOM, 1'b1);
        test_random_traffic(8'h00, 8'hFF, 170, 1'b0, RX_FREE, 1'b0);
        test_random_traffic(8'hFF, 8'h00, 170, 1'b1, RX_PATTERN, 1'b0);
        test_random_traffic(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 170,
                            1'b1, RX_RANDOM, 1'b0);
        test_output_hold();
        settle();
        repeat (10) @(posedge clk);
        $display("Run covered %0d bytes under %0d register settings, %0d results checked",
                 bytes_sent, settings_count + 1, results_checked);
        $display("  body %0d, good %0d, bad checksum %0d, incomplete %0d, bad length %0d",
                 kind_count[KIND_BODY], kind_count[KIND_GOOD], kind_count[KIND_BAD],
                 kind_count[KIND_INCOMPLETE], kind_count[KIND_BAD_LENGTH]);
        if (error_count == 0)
            $display("escaped_frame_deframer_top verification clean");
        else
            $display("escaped_frame_deframer_top verification failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("escaped_frame_deframer_top verification failed");
        $finish;
    end

endmodule
